### hw/rtl/dldf_pkg.sv
// shared types and constants for the definite-length block deframer
// no dependencies; imported by every module of the block

package dldf_pkg;

    localparam int unsigned MAX_LEN_DIGITS = 9;
    localparam int unsigned LEN_W          = 30;
    localparam int unsigned DIG_W          = 4;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_MAXC = CH_ZERO + 8'(MAX_LEN_DIGITS);

    localparam logic [1:0] KIND_HDR   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_COUNT = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

    // one held input item, handed from the input register to the parser
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_in_item;

endpackage

### hw/rtl/dldf_in_reg.sv
// input register stage of the deframer
// depends on dldf_pkg

module dldf_in_reg
    import dldf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_stream_byte,
    output logic       o_stall,
    input  logic       i_take,
    output t_in_item   o_item
);

    logic       r_vld;
    logic [7:0] r_data;
    logic       w_ready;

    // free, or being emptied this cycle
    assign w_ready = !r_vld || i_take;
    assign o_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= i_stream_byte;
        end
    end

    assign o_item.vld  = r_vld;
    assign o_item.data = r_data;

endmodule

### hw/rtl/dldf_parse.sv
// header parser state, per-byte step logic and result register
// depends on dldf_pkg

module dldf_parse
    import dldf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    output logic       o_take,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    t_phase             r_phase, n_phase;
    logic [DIG_W-1:0]   r_digits_left, n_digits_left;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_out_vld;
    logic [7:0]         r_pbyte, n_pbyte;
    logic [1:0]         r_kind, n_kind;
    logic               r_last, n_last;

    logic               w_is_digit;
    logic               w_cnt_ok;
    logic [DIG_W-1:0]   w_dval;
    logic [LEN_W-1:0]   w_len_acc;
    logic [LEN_W-1:0]   w_len_dec;
    logic [DIG_W-1:0]   w_dig_dec;

    assign o_take = i_item.vld && (!r_out_vld || !i_stall);

    assign w_is_digit = (i_item.data >= CH_ZERO) && (i_item.data <= CH_NINE);
    assign w_cnt_ok   = (i_item.data > CH_ZERO) && (i_item.data <= CH_MAXC);
    assign w_dval     = DIG_W'(i_item.data - CH_ZERO);
    // times ten as shift-add, wraps at the length width
    assign w_len_acc  = (r_len << 3) + (r_len << 1) + LEN_W'(w_dval);
    assign w_len_dec  = r_len - LEN_W'(1);
    assign w_dig_dec  = r_digits_left - DIG_W'(1);

    always_comb begin
        n_phase       = r_phase;
        n_digits_left = r_digits_left;
        n_len         = r_len;
        n_pbyte       = 8'd0;
        n_kind        = KIND_HDR;
        n_last        = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_item.data == CH_HASH) begin
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (w_cnt_ok) begin
                    n_digits_left = w_dval;
                    n_len         = '0;
                    n_phase       = PH_LEN;
                end else begin
                    n_kind  = KIND_ERR;
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN: begin
                if (w_is_digit) begin
                    n_len         = w_len_acc;
                    n_digits_left = w_dig_dec;
                    if (w_dig_dec == '0) begin
                        if (w_len_acc == '0) begin
                            n_kind  = KIND_EMPTY;
                            n_phase = PH_HUNT;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end else begin
                    n_kind        = KIND_ERR;
                    n_digits_left = '0;
                    n_phase       = PH_HUNT;
                end
            end
            PH_DATA: begin
                n_kind  = KIND_DATA;
                n_pbyte = i_item.data;
                n_len   = w_len_dec;
                if (w_len_dec == '0) begin
                    n_last  = 1'b1;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_digits_left <= '0;
            r_len         <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase       <= n_phase;
                r_digits_left <= n_digits_left;
                r_len         <= n_len;
                r_out_vld     <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pbyte <= n_pbyte;
            r_kind  <= n_kind;
            r_last  <= n_last;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_payload_byte = r_pbyte;
    assign o_kind         = r_kind;
    assign o_last         = r_last;

    a_last_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_kind != KIND_DATA) |-> !r_last)
        else $error("last flag on a non-payload result");

    a_len_digits_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) |-> (r_digits_left != '0))
        else $error("length phase with no digits left");

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != '0))
        else $error("payload phase with zero bytes left");

    a_data_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && (r_phase == PH_DATA) && (r_len == LEN_W'(1))
        |=> (r_phase == PH_HUNT) && r_last && (r_kind == KIND_DATA))
        else $error("final payload byte did not close the block");

endmodule

### hw/rtl/definite_length_block_deframer.sv
// top level of the definite-length block deframer
// depends on dldf_pkg, dldf_in_reg and dldf_parse
//
// usage:
//   input channel i_valid / i_stream_byte / o_stall carries raw link bytes,
//   one item per byte. output channel o_valid / o_payload_byte / o_kind /
//   o_last / i_stall gives exactly one result item per input item.
//   kind 0 marks a header or skipped byte, 1 a payload byte (o_last on the
//   final one), 2 a malformed header, 3 a block of length zero.
//   the parser hunts for '#', takes one count digit 1..9, that many length
//   digits, then passes the payload through and resumes hunting.
// datapath: an accepted byte goes through the input register, then the
//   per-byte step into the result register.
// throughput: one item per cycle unless i_stall holds a result (per-byte
//   parser update); while one waits, the input register can still fill once.
// reset: synchronous active-low i_rst_n empties both registers and puts
//   the parser back to hunting with cleared counters.
// stall: while i_stall holds a pending result, the held item waits in the
//   input register; once that is full too, o_stall rises and the input
//   side holds its item until space frees up.

module definite_length_block_deframer
    import dldf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_stream_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_kind,
    output logic       o_last,
    input  logic       i_stall
);

    t_in_item w_item;    // item held in the input register
    logic     w_take;    // parser consumes the held item this cycle

    dldf_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stream_byte (i_stream_byte),
        .o_stall       (o_stall),
        .i_take        (w_take),
        .o_item        (w_item)
    );

    dldf_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (w_item),
        .o_take         (w_take),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_payload_byte (o_payload_byte),
        .o_kind         (o_kind),
        .o_last         (o_last)
    );

endmodule
